// ----- design/vcdg_pkg.sv -----
// Shared types and constants for the volume gradient block.
package vcdg_pkg;

  localparam int POS_W     = 6;
  localparam int VOX_W     = 16;
  localparam int SIZE_W    = 7;
  localparam int INV_W     = 16;
  localparam int GRAD_W    = 34;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z  = 3'd5;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic       vld;
    logic       fw;
    logic [1:0] axis;
    logic       face;
    logic       flat;
  } samp_t;

  typedef struct packed {
    logic                     vld;
    logic [1:0]               axis;
    logic signed [GRAD_W-1:0] value;
  } res_t;

endpackage

// ----- design/vcdg_ifs.sv -----
// Handshake channel interfaces for request and result items.
interface vcdg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [vcdg_pkg::POS_W-1:0]    pos_x;
  logic [vcdg_pkg::POS_W-1:0]    pos_y;
  logic [vcdg_pkg::POS_W-1:0]    pos_z;
  logic [vcdg_pkg::VOX_W-1:0]    voxel_value;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, voxel_value, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, voxel_value, output ready);
endinterface

interface vcdg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vcdg_pkg::GRAD_W-1:0] grad_x;
  logic signed [vcdg_pkg::GRAD_W-1:0] grad_y;
  logic signed [vcdg_pkg::GRAD_W-1:0] grad_z;
  logic                              outside;

  modport source (output valid, grad_x, grad_y, grad_z, outside, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_z, outside, output ready);
endinterface

// ----- design/vcdg_grad_unit.sv -----
// Shared difference, multiply, face scaling and flat zeroing pipeline for one gradient axis at a time.
module vcdg_grad_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vcdg_pkg::samp_t              samp,
  input  logic [vcdg_pkg::VOX_W-1:0]   rd_data,
  input  logic [vcdg_pkg::INV_W-1:0]   inv_x,
  input  logic [vcdg_pkg::INV_W-1:0]   inv_y,
  input  logic [vcdg_pkg::INV_W-1:0]   inv_z,
  output vcdg_pkg::res_t               res
);

  vcdg_pkg::samp_t                  dtag_r;
  vcdg_pkg::samp_t                  dtag_nxt;
  vcdg_pkg::samp_t                  ptag_r;
  logic [vcdg_pkg::VOX_W-1:0]       bw_r;
  logic signed [vcdg_pkg::VOX_W:0]  diff_r;
  logic signed [vcdg_pkg::GRAD_W-1:0] prod_r;
  logic [vcdg_pkg::INV_W-1:0]       inv_sel;

  always_comb begin
    case (dtag_r.axis)
      vcdg_pkg::AX_X: inv_sel = inv_x;
      vcdg_pkg::AX_Y: inv_sel = inv_y;
      vcdg_pkg::AX_Z: inv_sel = inv_z;
      default:        inv_sel = '0;
    endcase
  end

  always_comb begin
    dtag_nxt     = samp;
    dtag_nxt.vld = samp.vld & samp.fw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtag_r <= '0;
      ptag_r <= '0;
    end else begin
      dtag_r <= dtag_nxt;
      ptag_r <= dtag_r;
      if (samp.vld && !samp.fw) begin
        bw_r <= rd_data;
      end
      diff_r <= $signed({1'b0, bw_r}) - $signed({1'b0, rd_data});
      prod_r <= vcdg_pkg::GRAD_W'(diff_r) * vcdg_pkg::GRAD_W'($signed({1'b0, inv_sel}));
    end
  end

  always_comb begin
    res.vld  = ptag_r.vld;
    res.axis = ptag_r.axis;
    if (ptag_r.flat) begin
      res.value = '0;
    end else if (ptag_r.face) begin
      res.value = prod_r <<< 1;
    end else begin
      res.value = prod_r;
    end
  end

endmodule

// ----- design/volume_central_difference_gradient.sv -----
// Top level: voxel store, query sequencer and result register for the 3D gradient.
// A load gives no result; an outside query goes via S_HOLD to the output register. A query
// inside the volume makes six neighbor reads on the single-port memory and passes them
// through the subtract/multiply pipeline, S_DRAIN and S_HOLD. Ready stays low until the
// query's result is registered. A query whose result meets a full output register waits.
// Synchronous active-low reset clears control, restores config defaults, keeps the store.
module volume_central_difference_gradient #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  vcdg_in_if.sink                          in_ch,
  vcdg_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [vcdg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [vcdg_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int XW = $clog2(MAX_X);
  localparam int YW = $clog2(MAX_Y);
  localparam int ZW = $clog2(MAX_Z);
  localparam int AW = XW + YW + ZW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int PW = vcdg_pkg::POS_W;
  localparam int SW = vcdg_pkg::SIZE_W;

  localparam logic [XW+PW-1:0] MX_L = (XW+PW)'(MAX_X);
  localparam logic [YW+PW-1:0] MY_L = (YW+PW)'(MAX_Y);
  localparam logic [ZW+PW-1:0] MZ_L = (ZW+PW)'(MAX_Z);
  localparam logic [SW-1:0] MX_CLIP = (MAX_X < 128) ? SW'(MAX_X) : SW'(127);
  localparam logic [SW-1:0] MY_CLIP = (MAX_Y < 128) ? SW'(MAX_Y) : SW'(127);
  localparam logic [SW-1:0] MZ_CLIP = (MAX_Z < 128) ? SW'(MAX_Z) : SW'(127);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DRAIN, S_HOLD} state_t;

  state_t                              state_r;
  logic [2:0]                          step_r;
  logic [PW-1:0]                       qx_r, qy_r, qz_r;
  logic [SW-1:0]                       nx_r, ny_r, nz_r;
  vcdg_pkg::samp_t                     samp_r;
  vcdg_pkg::samp_t                     samp_nxt;
  logic signed [vcdg_pkg::GRAD_W-1:0]  gx_r, gy_r, gz_r;
  logic                                outside_r;
  logic                                out_valid_r;
  logic signed [vcdg_pkg::GRAD_W-1:0]  out_gx_r, out_gy_r, out_gz_r;
  logic                                out_outside_r;

  logic [SW-1:0]                       size_x_r, size_y_r, size_z_r;
  logic [vcdg_pkg::INV_W-1:0]          inv_x_r, inv_y_r, inv_z_r;

  logic [vcdg_pkg::VOX_W-1:0]          mem [MEM_DEPTH];
  logic [vcdg_pkg::VOX_W-1:0]          rd_q_r;
  logic [AW-1:0]                       mem_addr;
  logic                                mem_we;

  logic [SW-1:0]                       ex, ey, ez;
  logic                                accept, is_query, q_outside;
  logic [PW-1:0]                       sel_p, nb_p, rx, ry, rz;
  logic [SW-1:0]                       sel_n;
  logic                                face_hi;
  logic [XW+PW-1:0]                    x_ext;
  logic [YW+PW-1:0]                    y_ext;
  logic [ZW+PW-1:0]                    z_ext;
  vcdg_pkg::res_t                      res;

  assign ex = (size_x_r > MX_CLIP) ? MX_CLIP : size_x_r;
  assign ey = (size_y_r > MY_CLIP) ? MY_CLIP : size_y_r;
  assign ez = (size_z_r > MZ_CLIP) ? MZ_CLIP : size_z_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_query    = (in_ch.req_type == vcdg_pkg::REQ_QUERY);
  assign q_outside   = ({1'b0, in_ch.pos_x} >= ex) || ({1'b0, in_ch.pos_y} >= ey) ||
                       ({1'b0, in_ch.pos_z} >= ez);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SW'(64);
      size_y_r <= SW'(64);
      size_z_r <= SW'(64);
      inv_x_r  <= vcdg_pkg::INV_W'(256);
      inv_y_r  <= vcdg_pkg::INV_W'(256);
      inv_z_r  <= vcdg_pkg::INV_W'(256);
    end else if (cfg_we) begin
      case (cfg_idx)
        vcdg_pkg::REG_SIZE_X: size_x_r <= cfg_wdata[SW-1:0];
        vcdg_pkg::REG_SIZE_Y: size_y_r <= cfg_wdata[SW-1:0];
        vcdg_pkg::REG_SIZE_Z: size_z_r <= cfg_wdata[SW-1:0];
        vcdg_pkg::REG_INV_X:  inv_x_r  <= cfg_wdata;
        vcdg_pkg::REG_INV_Y:  inv_y_r  <= cfg_wdata;
        vcdg_pkg::REG_INV_Z:  inv_z_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (step_r[2:1])
      vcdg_pkg::AX_X: begin sel_p = qx_r; sel_n = nx_r; end
      vcdg_pkg::AX_Y: begin sel_p = qy_r; sel_n = ny_r; end
      vcdg_pkg::AX_Z: begin sel_p = qz_r; sel_n = nz_r; end
      default:        begin sel_p = qx_r; sel_n = nx_r; end
    endcase
    face_hi = ({1'b0, sel_p} == (sel_n - SW'(1)));
    if (step_r[0]) begin
      nb_p = face_hi ? sel_p : sel_p + PW'(1);
    end else begin
      nb_p = (sel_p == '0) ? sel_p : sel_p - PW'(1);
    end
    rx = qx_r;
    ry = qy_r;
    rz = qz_r;
    case (step_r[2:1])
      vcdg_pkg::AX_X: rx = nb_p;
      vcdg_pkg::AX_Y: ry = nb_p;
      vcdg_pkg::AX_Z: rz = nb_p;
      default: ;
    endcase
    samp_nxt.vld  = (state_r == S_READ);
    samp_nxt.fw   = step_r[0];
    samp_nxt.axis = step_r[2:1];
    samp_nxt.face = (sel_p == '0) || face_hi;
    samp_nxt.flat = (sel_n <= SW'(1));

    if (state_r == S_IDLE) begin
      x_ext = (XW+PW)'(in_ch.pos_x);
      y_ext = (YW+PW)'(in_ch.pos_y);
      z_ext = (ZW+PW)'(in_ch.pos_z);
    end else begin
      x_ext = (XW+PW)'(rx);
      y_ext = (YW+PW)'(ry);
      z_ext = (ZW+PW)'(rz);
    end
    mem_addr = {z_ext[ZW-1:0], y_ext[YW-1:0], x_ext[XW-1:0]};
    mem_we   = accept && !is_query && (x_ext < MX_L) && (y_ext < MY_L) && (z_ext < MZ_L);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_ch.voxel_value;
    end
    rd_q_r <= mem[mem_addr];
  end

  vcdg_grad_unit u_grad (
    .clk     (clk),
    .rst_n   (rst_n),
    .samp    (samp_r),
    .rd_data (rd_q_r),
    .inv_x   (inv_x_r),
    .inv_y   (inv_y_r),
    .inv_z   (inv_z_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      samp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      samp_r <= samp_nxt;
      if (out_valid_r && out_ch.ready && state_r != S_HOLD) begin
        out_valid_r <= 1'b0;
      end
      if (res.vld) begin
        case (res.axis)
          vcdg_pkg::AX_X: gx_r <= res.value;
          vcdg_pkg::AX_Y: gy_r <= res.value;
          vcdg_pkg::AX_Z: gz_r <= res.value;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept && is_query) begin
            qx_r   <= in_ch.pos_x;
            qy_r   <= in_ch.pos_y;
            qz_r   <= in_ch.pos_z;
            nx_r   <= ex;
            ny_r   <= ey;
            nz_r   <= ez;
            step_r <= '0;
            if (q_outside) begin
              gx_r      <= '0;
              gy_r      <= '0;
              gz_r      <= '0;
              outside_r <= 1'b1;
              state_r   <= S_HOLD;
            end else begin
              outside_r <= 1'b0;
              state_r   <= S_READ;
            end
          end
        end
        S_READ: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (res.vld && res.axis == vcdg_pkg::AX_Z) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ch.ready) begin
            out_gx_r      <= gx_r;
            out_gy_r      <= gy_r;
            out_gz_r      <= gz_r;
            out_outside_r <= outside_r;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.grad_x  = out_gx_r;
  assign out_ch.grad_y  = out_gy_r;
  assign out_ch.grad_z  = out_gz_r;
  assign out_ch.outside = out_outside_r;

endmodule

// ----- design/vcdg_checker.sv -----
// Port-level assertions for the volume gradient block, bound to the top level.
module vcdg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_req_type,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [vcdg_pkg::GRAD_W-1:0] out_grad_x,
  input logic signed [vcdg_pkg::GRAD_W-1:0] out_grad_y,
  input logic signed [vcdg_pkg::GRAD_W-1:0] out_grad_z,
  input logic                              out_outside
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=>
      $stable(out_grad_x) && $stable(out_grad_y) && $stable(out_grad_z) &&
      $stable(out_outside))
    else $error("result payload changed while stalled");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside |-> out_grad_x == '0 && out_grad_y == '0 && out_grad_z == '0)
    else $error("outside result carries a nonzero gradient");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready && in_req_type == vcdg_pkg::REQ_QUERY |=> !in_ready)
    else $error("ready stayed high after a query item");

endmodule

bind volume_central_difference_gradient vcdg_checker u_vcdg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_grad_x  (out_ch.grad_x),
  .out_grad_y  (out_ch.grad_y),
  .out_grad_z  (out_ch.grad_z),
  .out_outside (out_ch.outside)
);
